>>> rtl/dmt_pkg.sv
// Shared types and constants for the integer matrix determinant block.
// Depends on nothing; every rtl file imports it.
package dmt_pkg;

   localparam int MAX_ORDER   = 8;
   localparam int ELEM_BITS   = 16;
   localparam int DET_BITS    = 64;
   localparam int ORDER_W     = 4;
   localparam int STORE_DEPTH = MAX_ORDER * MAX_ORDER;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int COUNT_W     = $clog2(STORE_DEPTH + 1);
   localparam int SUBSETS     = 1 << MAX_ORDER;
   localparam int SUB_W       = MAX_ORDER;
   localparam int COL_W       = $clog2(MAX_ORDER);
   localparam logic [ORDER_W-1:0] ORDER_RESET = ORDER_W'(3);

   typedef struct packed {
      logic                        en;
      logic [ADDR_W-1:0]           addr;
      logic signed [ELEM_BITS-1:0] data;
   } store_wr_type;

   typedef struct packed {
      logic [ORDER_W-1:0] order;
   } job_type;

   // Map the raw register value to a usable order: zero acts as one,
   // anything above the maximum saturates.
   function automatic logic [ORDER_W-1:0] clamp_order(input logic [ORDER_W-1:0] raw);
      logic [ORDER_W-1:0] res;
      res = raw;
      if (raw == '0) res = ORDER_W'(1);
      else if (raw > ORDER_W'(MAX_ORDER)) res = ORDER_W'(MAX_ORDER);
      return res;
   endfunction

endpackage

>>> rtl/dmt_front.sv
// Front end: holds the size register, accepts element beats, writes the
// matrix store and posts one job per complete matrix. Uses dmt_pkg.
module dmt_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [dmt_pkg::ORDER_W-1:0]     csr_wr_data,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  logic signed [dmt_pkg::ELEM_BITS-1:0] req_element,
   output dmt_pkg::store_wr_type           store_wr,
   output logic                            job_push,
   output dmt_pkg::job_type                job
);
   import dmt_pkg::*;

   logic [ORDER_W-1:0]   size_ff, size_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [ORDER_W-1:0]   order;
   logic [2*ORDER_W-1:0] total;
   logic                 accept;
   logic                 last;

   assign order  = clamp_order(size_ff);
   assign total  = order * order;
   assign accept = req_valid && !req_stall;
   assign last   = (2*ORDER_W)'(count_ff) + (2*ORDER_W)'(1) == total;

   always_comb begin
      size_in  = size_ff;
      count_in = count_ff;
      if (csr_wr_en) begin
         size_in  = csr_wr_data;
         count_in = '0;
      end else if (accept) begin
         count_in = last ? '0 : count_ff + COUNT_W'(1);
      end
   end

   assign store_wr.en   = accept;
   assign store_wr.addr = count_ff[ADDR_W-1:0];
   assign store_wr.data = req_element;
   assign job_push      = accept && last;
   assign job.order     = order;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff  <= ORDER_RESET;
         count_ff <= '0;
      end else begin
         size_ff  <= size_in;
         count_ff <= count_in;
      end
   end

endmodule

>>> rtl/dmt_queue.sv
// Two-entry job queue between front end and determinant engine.
// Uses dmt_pkg for the job type.
module dmt_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  dmt_pkg::job_type push_job,
   input  logic             pop,
   output logic             nonempty,
   output dmt_pkg::job_type head
);
   import dmt_pkg::*;

   job_type    slot_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] fill_ff, fill_in;
   logic       do_push, do_pop;

   assign do_push  = push && fill_ff != 2'd2;
   assign do_pop   = pop && fill_ff != 2'd0;
   assign nonempty = fill_ff != 2'd0;
   assign head     = slot_ff[rd_ptr_ff];

   always_comb begin
      fill_in = fill_ff;
      if (do_push && !do_pop) fill_in = fill_ff + 2'd1;
      else if (do_pop && !do_push) fill_in = fill_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= push_job;
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         if (do_push) wr_ptr_ff <= !wr_ptr_ff;
         if (do_pop) rd_ptr_ff <= !rd_ptr_ff;
         fill_ff <= fill_in;
      end
   end

endmodule

>>> rtl/dmt_back.sv
// Determinant engine: matrix store, minor table and one multiply-accumulate
// pipeline walked over column subsets. Uses dmt_pkg.
module dmt_back (
   input  logic                                clock,
   input  logic                                reset,
   input  dmt_pkg::store_wr_type               store_wr,
   input  logic                                job_valid,
   input  dmt_pkg::job_type                    job,
   output logic                                job_pop,
   output logic                                busy,
   input  logic                                rsp_stall,
   output logic                                rsp_valid,
   output logic signed [dmt_pkg::DET_BITS-1:0] rsp_determinant
);
   import dmt_pkg::*;

   typedef enum logic [2:0] {ST_IDLE, ST_INIT, ST_ISSUE, ST_DRAIN, ST_WRITE} state_type;

   logic signed [ELEM_BITS-1:0] mat_mem [STORE_DEPTH];
   logic [DET_BITS-1:0]         ps_mem [SUBSETS];

   state_type             state_ff;
   logic [ORDER_W-1:0]    order_ff;
   logic [SUB_W-1:0]      set_ff;
   logic [COL_W-1:0]      col_ff;
   logic                  pos_ff;
   logic                  drain_ff;
   logic                  v1_ff, neg1_ff, v2_ff, neg2_ff;
   logic signed [ELEM_BITS-1:0] mat_q_ff;
   logic [DET_BITS-1:0]   ps_q_ff, prod_ff, acc_ff;
   logic                  rsp_valid_ff;
   logic [DET_BITS-1:0]   rsp_det_ff;

   logic                  issue, col_last, set_last, out_free;
   logic [ORDER_W-1:0]    row;
   logic [2*ORDER_W-1:0]  row_base;
   logic [ADDR_W-1:0]     mat_addr;
   logic [SUB_W-1:0]      ps_addr, full;

   assign issue    = state_ff == ST_ISSUE && set_ff[col_ff];
   assign col_last = ORDER_W'(col_ff) == order_ff - ORDER_W'(1);
   assign row      = order_ff - ORDER_W'($countones(set_ff));
   assign row_base = row * order_ff;
   assign mat_addr = ADDR_W'(row_base + (2*ORDER_W)'(col_ff));
   assign ps_addr  = set_ff ^ (SUB_W'(1) << col_ff);
   assign full     = SUB_W'(((SUB_W+1)'(1) << order_ff) - (SUB_W+1)'(1));
   assign set_last = set_ff == full;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign job_pop         = state_ff == ST_IDLE && job_valid;
   assign busy            = state_ff != ST_IDLE;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_determinant = rsp_det_ff;

   always_ff @(posedge clock) begin
      if (store_wr.en) mat_mem[store_wr.addr] <= store_wr.data;
      if (state_ff == ST_INIT) ps_mem[0] <= DET_BITS'(1);
      if (state_ff == ST_WRITE) ps_mem[set_ff] <= acc_ff;
      if (issue) begin
         mat_q_ff <= mat_mem[mat_addr];
         ps_q_ff  <= ps_mem[ps_addr];
      end
   end

   always_ff @(posedge clock) begin
      neg1_ff <= pos_ff;
      neg2_ff <= neg1_ff;
      prod_ff <= ps_q_ff * DET_BITS'(mat_q_ff);
      if (v2_ff) acc_ff <= neg2_ff ? acc_ff - prod_ff : acc_ff + prod_ff;
      if (state_ff == ST_IDLE && job_valid) order_ff <= job.order;
      case (state_ff)
         ST_INIT: begin
            set_ff <= SUB_W'(1);
            col_ff <= '0;
            pos_ff <= 1'b0;
            acc_ff <= '0;
         end
         ST_ISSUE: begin
            if (issue) pos_ff <= !pos_ff;
            if (!col_last) col_ff <= col_ff + COL_W'(1);
            drain_ff <= 1'b1;
         end
         ST_DRAIN: drain_ff <= 1'b0;
         ST_WRITE: begin
            if (set_last && out_free) rsp_det_ff <= acc_ff;
            if (!set_last) begin
               set_ff <= set_ff + SUB_W'(1);
               col_ff <= '0;
               pos_ff <= 1'b0;
               acc_ff <= '0;
            end
         end
         default: ;
      endcase

      if (reset) begin
         state_ff     <= ST_IDLE;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v1_ff <= issue;
         v2_ff <= v1_ff;
         if (rsp_valid_ff && !rsp_stall && !(state_ff == ST_WRITE && set_last))
            rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE:  if (job_valid) state_ff <= ST_INIT;
            ST_INIT:  state_ff <= ST_ISSUE;
            ST_ISSUE: if (col_last) state_ff <= ST_DRAIN;
            // hold until the last product has landed in the accumulator
            ST_DRAIN: if (!drain_ff) state_ff <= ST_WRITE;
            ST_WRITE: begin
               if (!set_last) begin
                  state_ff <= ST_ISSUE;
               end else if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

>>> rtl/integer_matrix_determinant_top.sv
// Operation: n*n element beats load the matrix; after the last element beat one shared
// multiply-accumulate walks every column subset to reach the result beat.
// Throughput: one matrix at a time; req_stall rises after the last element beat
// and stays high until the result sits in the output register (it may still wait there).
// Reset (synchronous, high): size returns to 3, load count and queue clear,
// no result pending. Matrix store and minor table are not cleared.
module integer_matrix_determinant_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [dmt_pkg::ORDER_W-1:0]         csr_wr_data,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [dmt_pkg::ELEM_BITS-1:0] req_element,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [dmt_pkg::DET_BITS-1:0] rsp_determinant
);
   import dmt_pkg::*;

   store_wr_type store_wr;
   job_type      push_job, head_job;
   logic         job_push, job_pop, queue_nonempty, back_busy;

   assign req_stall = queue_nonempty || back_busy;

   dmt_front u_front (
      .clock, .reset, .csr_wr_en, .csr_wr_data,
      .req_valid, .req_stall, .req_element,
      .store_wr, .job_push, .job(push_job)
   );

   dmt_queue u_queue (
      .clock, .reset, .push(job_push), .push_job,
      .pop(job_pop), .nonempty(queue_nonempty), .head(head_job)
   );

   dmt_back u_back (
      .clock, .reset, .store_wr, .job_valid(queue_nonempty), .job(head_job),
      .job_pop, .busy(back_busy), .rsp_stall, .rsp_valid, .rsp_determinant
   );

endmodule

>>> rtl/dmt_checker.sv
// Port-level checks for the determinant block, bound to the top level.
// Uses dmt_pkg for port widths.
module dmt_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_stall,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic signed [dmt_pkg::DET_BITS-1:0] rsp_determinant
);
   import dmt_pkg::*;

   // a stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_determinant))
      else $error("result beat dropped or changed under stall");

   // reset leaves no result and an open input
   assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("state after reset not idle");

   // a new result only comes while the input side is held off
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without a computation in progress");

endmodule

bind integer_matrix_determinant_top dmt_checker u_dmt_checker (
   .clock, .reset, .req_stall, .rsp_valid, .rsp_stall, .rsp_determinant
);
